// ----- hw/rtl/dfce_pkg.sv -----
`timescale 1ns / 1ps

package dfce_pkg;

   localparam int CHANNELS  = 64;
   localparam int CMD_BYTES = 20;

   localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int BUF_AW = $clog2(CMD_BYTES);
   localparam int LEN_W  = $clog2(CMD_BYTES + 1);

   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_V     = 8'h56;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'd32;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] KIND_LEVEL    = 2'd0;
   localparam logic [1:0] KIND_ACK      = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BYTE,
      ST_RESP,
      ST_TRD,
      ST_TCHK,
      ST_DIV,
      ST_WB,
      ST_EMIT,
      ST_ADV,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
      logic [7:0] elapsed_periods;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] channel;
      logic [7:0] level;
      logic       last;
   } rsp_type;

endpackage

// ----- hw/rtl/dmx_fade_command_engine_core.sv -----
`timescale 1ns / 1ps

// DMX fade command engine. Serial command bytes (opcode 0) build up a
// command; a byte of 32 or below clears it, a twentieth byte clears it and
// returns one overflow beat, and a closing 'E' decodes ScccVxxxE or
// FcccVxxxPnnnE and returns one acknowledge beat. A byte that causes a beat
// passes through the decode and response states and waits in the response
// state while the output stalls. A fade tick (opcode 1) walks all 64 channels
// through one shared datapath: each channel passes through the table read,
// the check and the advance (the 8x8 multiply shares the check state). A
// channel that jumps adds a writeback and an emit, and a channel still fading
// adds a restoring divider as well. Stalls on the result side can hold a tick.
// Each changed level goes out as one beat; the final beat of a tick carries
// last. The request side is not ready while an item is in work.

module dmx_fade_command_engine_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dfce_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dfce_pkg::rsp_type rsp_data
);

   localparam int CH_AW  = dfce_pkg::CH_AW;
   localparam int LEN_W  = dfce_pkg::LEN_W;

   dfce_pkg::state_type state_ff, state_in;

   // command buffer and length
   logic [7:0]       buf_ff [dfce_pkg::CMD_BYTES];
   logic [7:0]       buf_in [dfce_pkg::CMD_BYTES];
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;

   // tick walk
   logic [CH_AW-1:0] idx_ff, idx_in;
   logic [7:0]       el_ff, el_in;
   logic [7:0]       lvl_ff, lvl_in;
   logic [7:0]       tgt_ff, tgt_in;
   logic [7:0]       stp_ff, stp_in;
   logic [7:0]       nv_ff, nv_in;
   logic             chg_ff, chg_in;
   logic [7:0]       rem_ff, rem_in;
   logic [15:0]      quo_ff, quo_in;
   logic [3:0]       cnt_ff, cnt_in;

   // held result, sent once the next one (or the end of the tick) is known
   logic             pend_valid_ff, pend_valid_in;
   logic [CH_AW-1:0] pend_ch_ff, pend_ch_in;
   logic [7:0]       pend_lvl_ff, pend_lvl_in;

   logic              rsp_valid_ff, rsp_valid_in;
   dfce_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // per-entry valid bits give the all-zero reset of the channel tables
   logic [dfce_pkg::CHANNELS-1:0] lvl_vld_ff, lvl_vld_in;
   logic [dfce_pkg::CHANNELS-1:0] tgt_vld_ff, tgt_vld_in;
   logic [dfce_pkg::CHANNELS-1:0] stp_vld_ff, stp_vld_in;
   logic                          lvl_rv_ff, tgt_rv_ff, stp_rv_ff;

   logic             lvl_we, tgt_we, stp_we;
   logic [CH_AW-1:0] tgt_wa, stp_wa;
   logic [7:0]       lvl_wd, tgt_wd, stp_wd;
   logic [7:0]       lvl_rd, tgt_rd, stp_rd;
   logic [7:0]       lvl_q, tgt_q, stp_q;

   logic       req_fire, out_free;
   logic [7:0] pos [13];
   logic [9:0] num_chan, num_val, num_per;
   logic       dig_chan, dig_val, dig_per;
   logic       cmd_s, cmd_f;
   logic [8:0] div_sh;
   logic       div_ge;
   logic [7:0] absd;
   logic       up;

   dfce_ram #(.WIDTH(8), .DEPTH(dfce_pkg::CHANNELS)) u_lvl_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (idx_ff),
      .wr_data (lvl_wd),
      .rd_addr (idx_ff),
      .rd_data (lvl_rd)
   );

   dfce_ram #(.WIDTH(8), .DEPTH(dfce_pkg::CHANNELS)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (tgt_we),
      .wr_addr (tgt_wa),
      .wr_data (tgt_wd),
      .rd_addr (idx_ff),
      .rd_data (tgt_rd)
   );

   dfce_ram #(.WIDTH(8), .DEPTH(dfce_pkg::CHANNELS)) u_stp_ram (
      .clock   (clock),
      .wr_en   (stp_we),
      .wr_addr (stp_wa),
      .wr_data (stp_wd),
      .rd_addr (idx_ff),
      .rd_data (stp_rd)
   );

   assign lvl_q = lvl_rv_ff ? lvl_rd : 8'd0;
   assign tgt_q = tgt_rv_ff ? tgt_rd : 8'd0;
   assign stp_q = stp_rv_ff ? stp_rd : 8'd0;

   assign req_ready = (state_ff == dfce_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // buffer positions at or past the length read as zero
   always_comb begin
      for (int k = 0; k < 13; k++) begin
         pos[k] = (LEN_W'(k) < len_ff) ? buf_ff[k] : 8'd0;
      end
   end

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= dfce_pkg::CHAR_ZERO) && (c <= dfce_pkg::CHAR_NINE);
   endfunction

   function automatic logic [9:0] num3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [3:0] da, db, dc;
      da = 4'(a - dfce_pkg::CHAR_ZERO);
      db = 4'(b - dfce_pkg::CHAR_ZERO);
      dc = 4'(c - dfce_pkg::CHAR_ZERO);
      return (10'(da) * 10'd100) + (10'(db) * 10'd10) + 10'(dc);
   endfunction

   assign dig_chan = is_digit(pos[1]) && is_digit(pos[2]) && is_digit(pos[3]);
   assign dig_val  = is_digit(pos[5]) && is_digit(pos[6]) && is_digit(pos[7]);
   assign dig_per  = is_digit(pos[9]) && is_digit(pos[10]) && is_digit(pos[11]);
   assign num_chan = num3(pos[1], pos[2], pos[3]);
   assign num_val  = num3(pos[5], pos[6], pos[7]);
   assign num_per  = num3(pos[9], pos[10], pos[11]);

   assign cmd_s = (pos[0] == dfce_pkg::CHAR_S) && (pos[4] == dfce_pkg::CHAR_V) &&
                  (pos[8] == dfce_pkg::CHAR_E) && dig_chan && dig_val &&
                  (num_chan < 10'(dfce_pkg::CHANNELS));
   assign cmd_f = (pos[0] == dfce_pkg::CHAR_F) && (pos[4] == dfce_pkg::CHAR_V) &&
                  (pos[8] == dfce_pkg::CHAR_P) && (pos[12] == dfce_pkg::CHAR_E) &&
                  dig_chan && dig_val && dig_per &&
                  (num_chan < 10'(dfce_pkg::CHANNELS));

   // shared divider step and fade direction
   assign div_sh = {rem_ff, quo_ff[15]};
   assign div_ge = div_sh >= {1'b0, stp_ff};
   assign up     = tgt_ff > lvl_ff;
   assign absd   = up ? (tgt_ff - lvl_ff) : (lvl_ff - tgt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfce_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.opcode == dfce_pkg::OP_TICK) begin
                  state_in = dfce_pkg::ST_TRD;
               end else if (req_data.rx_byte > dfce_pkg::CHAR_SPACE &&
                            ((len_ff + 1'b1) > LEN_W'(dfce_pkg::CMD_BYTES - 1) ||
                             req_data.rx_byte == dfce_pkg::CHAR_E)) begin
                  state_in = dfce_pkg::ST_BYTE;
               end
            end
         end
         dfce_pkg::ST_BYTE: state_in = dfce_pkg::ST_RESP;
         dfce_pkg::ST_RESP: begin
            if (out_free) state_in = dfce_pkg::ST_IDLE;
         end
         dfce_pkg::ST_TRD:  state_in = dfce_pkg::ST_TCHK;
         dfce_pkg::ST_TCHK: begin
            if (lvl_q == tgt_q) state_in = dfce_pkg::ST_ADV;
            else if (stp_q == 8'd0) state_in = dfce_pkg::ST_WB;
            else state_in = dfce_pkg::ST_DIV;
         end
         dfce_pkg::ST_DIV: begin
            if (cnt_ff == 4'd15) state_in = dfce_pkg::ST_WB;
         end
         dfce_pkg::ST_WB: begin
            state_in = (chg_in) ? dfce_pkg::ST_EMIT : dfce_pkg::ST_ADV;
         end
         dfce_pkg::ST_EMIT: begin
            if (!pend_valid_ff || out_free) state_in = dfce_pkg::ST_ADV;
         end
         dfce_pkg::ST_ADV: begin
            state_in = (idx_ff == CH_AW'(dfce_pkg::CHANNELS - 1)) ?
                       dfce_pkg::ST_FLUSH : dfce_pkg::ST_TRD;
         end
         dfce_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || out_free) state_in = dfce_pkg::ST_IDLE;
         end
         default: state_in = dfce_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      buf_in        = buf_ff;
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      idx_in        = idx_ff;
      el_in         = el_ff;
      lvl_in        = lvl_ff;
      tgt_in        = tgt_ff;
      stp_in        = stp_ff;
      nv_in         = nv_ff;
      chg_in        = chg_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      pend_lvl_in   = pend_lvl_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      lvl_vld_in    = lvl_vld_ff;
      tgt_vld_in    = tgt_vld_ff;
      stp_vld_in    = stp_vld_ff;
      lvl_we        = 1'b0;
      lvl_wd        = nv_ff;
      tgt_we        = 1'b0;
      tgt_wa        = num_chan[CH_AW-1:0];
      tgt_wd        = num_val[7:0];
      stp_we        = 1'b0;
      stp_wa        = idx_ff;
      stp_wd        = 8'd0;

      case (state_ff)
         dfce_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.opcode == dfce_pkg::OP_TICK) begin
                  el_in         = req_data.elapsed_periods;
                  idx_in        = '0;
                  pend_valid_in = 1'b0;
               end else if (req_data.rx_byte > dfce_pkg::CHAR_SPACE) begin
                  for (int i = 0; i < dfce_pkg::CMD_BYTES; i++) begin
                     if (len_ff == LEN_W'(i)) buf_in[i] = req_data.rx_byte;
                  end
                  len_in = len_ff + 1'b1;
                  ovf_in = (len_ff + 1'b1) > LEN_W'(dfce_pkg::CMD_BYTES - 1);
               end else begin
                  len_in = '0;
               end
            end
         end
         dfce_pkg::ST_BYTE: begin
            // decode against the buffer, closing byte included
            if (!ovf_ff && (cmd_s || cmd_f)) begin
               tgt_we = 1'b1;
               stp_we = 1'b1;
               stp_wa = num_chan[CH_AW-1:0];
               stp_wd = cmd_s ? 8'd1 : num_per[7:0];
               tgt_vld_in[num_chan[CH_AW-1:0]] = 1'b1;
               stp_vld_in[num_chan[CH_AW-1:0]] = 1'b1;
            end
            len_in = '0;
         end
         dfce_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.kind    = ovf_ff ? dfce_pkg::KIND_OVERFLOW : dfce_pkg::KIND_ACK;
               rsp_data_in.channel = 6'd0;
               rsp_data_in.level   = 8'd0;
               rsp_data_in.last    = 1'b1;
            end
         end
         dfce_pkg::ST_TCHK: begin
            lvl_in = lvl_q;
            tgt_in = tgt_q;
            stp_in = stp_q;
            rem_in = 8'd0;
            cnt_in = 4'd0;
            quo_in = (lvl_q > tgt_q) ? (lvl_q - tgt_q) * el_ff : (tgt_q - lvl_q) * el_ff;
         end
         dfce_pkg::ST_DIV: begin
            rem_in = div_ge ? 8'(div_sh - {1'b0, stp_ff}) : div_sh[7:0];
            quo_in = {quo_ff[14:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
         end
         dfce_pkg::ST_WB: begin
            if (stp_ff == 8'd0) begin
               nv_in  = tgt_ff;
               chg_in = 1'b1;
            end else begin
               // clamp at the target instead of overshooting
               if (quo_ff >= {8'd0, absd}) nv_in = tgt_ff;
               else nv_in = up ? (lvl_ff + quo_ff[7:0]) : (lvl_ff - quo_ff[7:0]);
               chg_in = (quo_ff != 16'd0);
               stp_we = 1'b1;
               stp_wd = (stp_ff < el_ff) ? 8'd0 : (stp_ff - el_ff);
               stp_vld_in[idx_ff] = 1'b1;
            end
            lvl_we = chg_in;
            lvl_wd = nv_in;
            if (chg_in) lvl_vld_in[idx_ff] = 1'b1;
         end
         dfce_pkg::ST_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in        = 1'b1;
                  rsp_data_in.kind    = dfce_pkg::KIND_LEVEL;
                  rsp_data_in.channel = 6'(pend_ch_ff);
                  rsp_data_in.level   = pend_lvl_ff;
                  rsp_data_in.last    = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_ch_in    = idx_ff;
               pend_lvl_in   = nv_ff;
            end
         end
         dfce_pkg::ST_ADV: begin
            if (idx_ff != CH_AW'(dfce_pkg::CHANNELS - 1)) idx_in = idx_ff + 1'b1;
         end
         dfce_pkg::ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.kind    = dfce_pkg::KIND_LEVEL;
               rsp_data_in.channel = 6'(pend_ch_ff);
               rsp_data_in.level   = pend_lvl_ff;
               rsp_data_in.last    = 1'b1;
               pend_valid_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dfce_pkg::ST_IDLE;
         len_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         lvl_vld_ff    <= '0;
         tgt_vld_ff    <= '0;
         stp_vld_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         lvl_vld_ff    <= lvl_vld_in;
         tgt_vld_ff    <= tgt_vld_in;
         stp_vld_ff    <= stp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff      <= buf_in;
      ovf_ff      <= ovf_in;
      idx_ff      <= idx_in;
      el_ff       <= el_in;
      lvl_ff      <= lvl_in;
      tgt_ff      <= tgt_in;
      stp_ff      <= stp_in;
      nv_ff       <= nv_in;
      chg_ff      <= chg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      pend_ch_ff  <= pend_ch_in;
      pend_lvl_ff <= pend_lvl_in;
      rsp_data_ff <= rsp_data_in;
      // valid bits follow the read address with the same latency as the data
      lvl_rv_ff   <= lvl_vld_ff[idx_ff];
      tgt_rv_ff   <= tgt_vld_ff[idx_ff];
      stp_rv_ff   <= stp_vld_ff[idx_ff];
   end

   // a held level beat never survives into idle
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pend_valid_ff)
      else $error("held level beat left behind at idle");

   // once taken, a tick keeps the request side closed for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.opcode == dfce_pkg::OP_TICK) |=> !req_ready)
      else $error("request accepted during a tick walk");

   // the divider only runs on a nonzero step count
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dfce_pkg::ST_DIV) |-> (stp_ff != 8'd0))
      else $error("divide by zero steps");

endmodule

// ----- hw/rtl/dfce_ram.sv -----
`timescale 1ns / 1ps

module dfce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
